[src/svd_pkg.sv]
// Shared constants, types and the sector lookup of the space vector PWM core.
package svd_pkg;

  localparam int VOLT_WIDTH_DEF     = 16;
  localparam int DUTY_FRAC_BITS_DEF = 15;
  localparam int PROJ_SHIFT         = 17;
  localparam int SQRT3_W            = 18;
  localparam logic signed [SQRT3_W-1:0] SQRT3_Q16 = 18'sd113512;

  localparam int SECTOR_W      = 3;
  localparam int DUTY_W        = 16;
  localparam int OUT_TDATA_W   = 56;
  localparam int OUT_TUSER_W   = 1;

  localparam logic [SECTOR_W-1:0] SEC_NONE = 3'd0;
  localparam logic [SECTOR_W-1:0] SEC_1    = 3'd1;
  localparam logic [SECTOR_W-1:0] SEC_2    = 3'd2;
  localparam logic [SECTOR_W-1:0] SEC_3    = 3'd3;
  localparam logic [SECTOR_W-1:0] SEC_4    = 3'd4;
  localparam logic [SECTOR_W-1:0] SEC_5    = 3'd5;
  localparam logic [SECTOR_W-1:0] SEC_6    = 3'd6;

  typedef struct packed {
    logic                vld;
    logic [SECTOR_W-1:0] sector;
    logic                ovm;
    logic                bad;
  } side_t;

  function automatic logic [SECTOR_W-1:0] sector_of(input logic [2:0] code);
    logic [SECTOR_W-1:0] s;
    case (code)
      3'd3:    s = SEC_1;
      3'd1:    s = SEC_2;
      3'd5:    s = SEC_3;
      3'd4:    s = SEC_4;
      3'd6:    s = SEC_5;
      3'd2:    s = SEC_6;
      default: s = SEC_NONE;
    endcase
    return s;
  endfunction

endpackage

[src/svd_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module svd_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 35,
  parameter int QUO_W = 16
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W:0]   trial;
    logic [DEN_W-1:0] dv;
    logic [QUO_W-1:0] qin;
    logic             ge;

    if (k == 0) begin : g_first
      assign trial = {1'b0, DEN_W'(num_i)};
      assign dv    = den_i;
      assign qin   = '0;
    end else begin : g_rest
      assign trial = {rem_q[k-1], 1'b0};
      assign dv    = den_q[k-1];
      assign qin   = quo_q[k-1];
    end

    assign ge = trial >= {1'b0, dv};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DEN_W'(trial - {1'b0, dv}) : DEN_W'(trial);
        den_q[k] <= dv;
        quo_q[k] <= {qin[QUO_W-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

[src/svpwm_sector_duty_core.sv]
// Seven-segment space vector PWM core: sector detection and phase duties.
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  s_axis   | in  | v_alpha, v_beta, bus_voltage                | -
//  m_axis   | out | sector, duty_a, duty_b, duty_c              | fault
//
//  One transaction per cycle sustained while m_axis accepts; three front stages (scaled
//  axes, projections and sector, overmodulation test), one divider stage per quotient bit,
//  one output stage. Two dividers run side by side; the divider depth dominates the latency.
//  Reset clears all valid bits and the sector and flag side-band; other payload registers are not reset.
//  A stall on m_axis freezes the whole pipeline and drops s_axis_tready_o.
module svpwm_sector_duty_core #(
  parameter int VOLT_WIDTH     = svd_pkg::VOLT_WIDTH_DEF,
  parameter int DUTY_FRAC_BITS = svd_pkg::DUTY_FRAC_BITS_DEF,
  localparam int IN_TDATA_W    = ((3 * VOLT_WIDTH + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // v_alpha, v_beta, bus_voltage
  input  logic [IN_TDATA_W-1:0]              s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // sector, duty_a, duty_b, duty_c
  output logic [svd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // fault
  output logic [svd_pkg::OUT_TUSER_W-1:0]    m_axis_tuser_o
);

  localparam int PW = VOLT_WIDTH + 19;
  localparam int MW = VOLT_WIDTH + 18;
  localparam int SW = VOLT_WIDTH + 19;
  localparam int BW = VOLT_WIDTH + svd_pkg::SQRT3_W;
  localparam int QW = DUTY_FRAC_BITS + 1;
  localparam int XW = QW + 1;
  localparam logic [XW-1:0] ONE_X = XW'(1) << DUTY_FRAC_BITS;
  localparam logic [XW-1:0] HALF_X = ONE_X >> 1;
  localparam int SW_ = svd_pkg::SECTOR_W;
  localparam int DW_ = svd_pkg::DUTY_W;

  function automatic logic [MW-1:0] nonneg(input logic signed [PW-1:0] x);
    return (x > 0) ? MW'(x) : '0;
  endfunction

  logic adv;
  logic m_vld_q;
  assign adv             = !m_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  logic signed [VOLT_WIDTH-1:0] a_in, b_in;
  logic        [VOLT_WIDTH-1:0] vbus_in;
  assign a_in    = $signed(s_axis_tdata_i[VOLT_WIDTH-1:0]);
  assign b_in    = $signed(s_axis_tdata_i[2*VOLT_WIDTH-1:VOLT_WIDTH]);
  assign vbus_in = s_axis_tdata_i[3*VOLT_WIDTH-1:2*VOLT_WIDTH];

  // stage A: scaled axes
  logic                  a_vld_q;
  logic signed [PW-1:0]  a3_q, bs_q;
  logic [VOLT_WIDTH-1:0] a_vbus_q;
  logic signed [PW-1:0]  a_ext, a3_d, bs_d;
  logic signed [BW-1:0]  bs_p;
  assign a_ext = PW'(a_in);
  assign a3_d  = ((a_ext <<< 1) + a_ext) <<< 16;
  assign bs_p  = b_in * svd_pkg::SQRT3_Q16;
  assign bs_d  = PW'(bs_p);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a3_q     <= a3_d;
      bs_q     <= bs_d;
      a_vbus_q <= vbus_in;
    end
  end

  // stage B: projections, sector, sector projections
  logic signed [PW-1:0]  p1, p2, p3;
  logic [2:0]            code;
  logic [SW_-1:0]        sec_d;
  logic [MW-1:0]         m1_d, m2_d;
  assign p1    = bs_q <<< 1;
  assign p2    = a3_q - bs_q;
  assign p3    = -(a3_q + bs_q);
  assign code  = {p3 > 0, p2 > 0, p1 > 0};
  assign sec_d = svd_pkg::sector_of(code);

  always_comb begin
    case (sec_d)
      svd_pkg::SEC_1: begin m1_d = nonneg(p2);  m2_d = nonneg(p1);  end
      svd_pkg::SEC_2: begin m1_d = nonneg(-p2); m2_d = nonneg(-p3); end
      svd_pkg::SEC_3: begin m1_d = nonneg(p1);  m2_d = nonneg(p3);  end
      svd_pkg::SEC_4: begin m1_d = nonneg(-p1); m2_d = nonneg(-p2); end
      svd_pkg::SEC_5: begin m1_d = nonneg(p3);  m2_d = nonneg(p2);  end
      svd_pkg::SEC_6: begin m1_d = nonneg(-p3); m2_d = nonneg(-p1); end
      default:        begin m1_d = '0;          m2_d = '0;          end
    endcase
  end

  logic                  b_vld_q;
  logic [SW_-1:0]        b_sec_q;
  logic [MW-1:0]         b_m1_q, b_m2_q;
  logic [VOLT_WIDTH-1:0] b_vbus_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_sec_q  <= sec_d;
      b_m1_q   <= m1_d;
      b_m2_q   <= m2_d;
      b_vbus_q <= a_vbus_q;
    end
  end

  // stage C: overmodulation test and divisor select
  logic [SW-1:0] den_d, sum_d;
  assign den_d = SW'(b_vbus_q) << svd_pkg::PROJ_SHIFT;
  assign sum_d = SW'(b_m1_q) + SW'(b_m2_q);

  svd_pkg::side_t c_side_q;
  logic [MW-1:0]  c_m1_q, c_m2_q;
  logic [SW-1:0]  c_den1_q, c_den2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_side_q <= '0;
    end else if (adv) begin
      c_side_q.vld    <= b_vld_q;
      c_side_q.sector <= b_sec_q;
      c_side_q.ovm    <= sum_d > den_d;
      c_side_q.bad    <= (b_sec_q == svd_pkg::SEC_NONE) || (b_vbus_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_m1_q   <= b_m1_q;
      c_m2_q   <= b_m2_q;
      c_den1_q <= (sum_d > den_d) ? sum_d : den_d;
      c_den2_q <= den_d;
    end
  end

  // divider stages
  logic [QW-1:0] q1, q2;

  svd_div #(.NUM_W(MW), .DEN_W(SW), .QUO_W(QW)) u_div1 (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (c_m1_q),
    .den_i (c_den1_q),
    .quo_o (q1)
  );

  svd_div #(.NUM_W(MW), .DEN_W(SW), .QUO_W(QW)) u_div2 (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (c_m2_q),
    .den_i (c_den2_q),
    .quo_o (q2)
  );

  svd_pkg::side_t side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[k] <= '0;
      end else if (adv) begin
        side_q[k] <= (k == 0) ? c_side_q : side_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // output stage: segment times and phase map
  svd_pkg::side_t sd;
  logic [XW-1:0] t1, t2, tsum, t0, ta, tb, tc, da, db, dc;
  logic          flt;
  assign sd   = side_q[QW-1];
  assign t1   = {1'b0, q1};
  assign t2   = sd.ovm ? (ONE_X - t1) : {1'b0, q2};
  assign tsum = t1 + t2;
  assign t0   = (tsum <= ONE_X) ? ((ONE_X - tsum) >> 1) : '0;
  assign ta   = t0 + tsum;
  assign tb   = t0 + t2;
  assign tc   = t0;

  always_comb begin
    if (sd.bad) begin
      da = HALF_X; db = HALF_X; dc = HALF_X;
    end else begin
      case (sd.sector)
        svd_pkg::SEC_1: begin da = ta; db = tb; dc = tc; end
        svd_pkg::SEC_2: begin da = tb; db = ta; dc = tc; end
        svd_pkg::SEC_3: begin da = tc; db = ta; dc = tb; end
        svd_pkg::SEC_4: begin da = tc; db = tb; dc = ta; end
        svd_pkg::SEC_5: begin da = tb; db = tc; dc = ta; end
        default:        begin da = ta; db = tc; dc = tb; end
      endcase
    end
  end

  assign flt = sd.bad || (da > ONE_X) || (db > ONE_X) || (dc > ONE_X);

  logic [SW_-1:0] sec_q;
  logic [DW_-1:0] da_q, db_q, dc_q;
  logic           flt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q <= sd.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sec_q <= sd.sector;
      da_q  <= DW_'(da);
      db_q  <= DW_'(db);
      dc_q  <= DW_'(dc);
      flt_q <= flt;
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = {5'd0, dc_q, db_q, da_q, sec_q};
  assign m_axis_tuser_o  = flt_q;

endmodule

[src/svd_checker.sv]
// Port-level checks of the space vector PWM core and their binding.
module svd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [svd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [svd_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output transaction changed while stalled");

  a_no_sector_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[2:0] == svd_pkg::SEC_NONE) |-> m_axis_tuser_o[0])
    else $error("undetermined sector without fault");

  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[2:0] <= svd_pkg::SEC_6)
    else $error("sector out of range");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while output stalled");

endmodule

bind svpwm_sector_duty_core svd_checker u_svd_checker (.*);

[bench/svpwm_sector_duty_core_tb.sv]
// Self-checking bench for the space vector PWM sector and duty core.
`timescale 1ns / 100ps

module svpwm_sector_duty_core_tb;

  localparam int VW       = 16;
  localparam int FB       = 15;
  localparam int IN_W     = ((3 * VW + 7) / 8) * 8;
  localparam int WDOG_MAX = 5000;
  localparam int N_RAND   = 1200;

  typedef struct {
    logic [svd_pkg::SECTOR_W-1:0] sector;
    logic [svd_pkg::DUTY_W-1:0]   duty_a;
    logic [svd_pkg::DUTY_W-1:0]   duty_b;
    logic [svd_pkg::DUTY_W-1:0]   duty_c;
    logic                         fault;
  } duty_set_t;

  class duty_scoreboard;
    duty_set_t pending_q[$];
    int        errors;

    function duty_set_t predict(logic [IN_W-1:0] d);
      duty_set_t r;
      longint a, b, a3, bs, p1, p2, p3, x1, x2;
      longint unsigned vbus, m1, m2, den, t1, t2, t0, ta, tb, tc, da, db, dc;
      longint unsigned one;
      logic [2:0] code;
      one  = 64'd1 << FB;
      a    = longint'($signed(d[VW-1:0]));
      b    = longint'($signed(d[2*VW-1:VW]));
      vbus = longint'(d[3*VW-1:2*VW]);
      a3   = a * 3 * 65536;
      bs   = b * 113512;
      p1   = 2 * bs;
      p2   = a3 - bs;
      p3   = -(a3 + bs);
      code = {p3 > 0, p2 > 0, p1 > 0};
      case (code)
        3'd3:    r.sector = svd_pkg::SEC_1;
        3'd1:    r.sector = svd_pkg::SEC_2;
        3'd5:    r.sector = svd_pkg::SEC_3;
        3'd4:    r.sector = svd_pkg::SEC_4;
        3'd6:    r.sector = svd_pkg::SEC_5;
        3'd2:    r.sector = svd_pkg::SEC_6;
        default: r.sector = svd_pkg::SEC_NONE;
      endcase
      case (r.sector)
        svd_pkg::SEC_1: begin x1 = p2;  x2 = p1;  end
        svd_pkg::SEC_2: begin x1 = -p2; x2 = -p3; end
        svd_pkg::SEC_3: begin x1 = p1;  x2 = p3;  end
        svd_pkg::SEC_4: begin x1 = -p1; x2 = -p2; end
        svd_pkg::SEC_5: begin x1 = p3;  x2 = p2;  end
        svd_pkg::SEC_6: begin x1 = -p3; x2 = -p1; end
        default:        begin x1 = 0;   x2 = 0;   end
      endcase
      m1 = (x1 > 0) ? longint'(x1) : 0;
      m2 = (x2 > 0) ? longint'(x2) : 0;
      r.fault = 1'b0;
      if (r.sector == svd_pkg::SEC_NONE || vbus == 0) begin
        da = one >> 1; db = one >> 1; dc = one >> 1;
        r.fault = 1'b1;
      end else begin
        den = vbus << svd_pkg::PROJ_SHIFT;
        if (m1 + m2 > den) begin
          t1 = (m1 << FB) / (m1 + m2);
          t2 = one - t1;
        end else begin
          t1 = (m1 << FB) / den;
          t2 = (m2 << FB) / den;
        end
        t0 = (t1 + t2 <= one) ? ((one - t1 - t2) >> 1) : 0;
        ta = t0 + t1 + t2;
        tb = t0 + t2;
        tc = t0;
        case (r.sector)
          svd_pkg::SEC_1: begin da = ta; db = tb; dc = tc; end
          svd_pkg::SEC_2: begin da = tb; db = ta; dc = tc; end
          svd_pkg::SEC_3: begin da = tc; db = ta; dc = tb; end
          svd_pkg::SEC_4: begin da = tc; db = tb; dc = ta; end
          svd_pkg::SEC_5: begin da = tb; db = tc; dc = ta; end
          default:        begin da = ta; db = tc; dc = tb; end
        endcase
        if (da > one || db > one || dc > one) r.fault = 1'b1;
      end
      r.duty_a = da[svd_pkg::DUTY_W-1:0];
      r.duty_b = db[svd_pkg::DUTY_W-1:0];
      r.duty_c = dc[svd_pkg::DUTY_W-1:0];
      return r;
    endfunction

    function void note_vector(logic [IN_W-1:0] d);
      pending_q.push_back(predict(d));
    endfunction

    function void check_duties(logic [svd_pkg::OUT_TDATA_W-1:0] td,
                               logic [svd_pkg::OUT_TUSER_W-1:0] tu);
      duty_set_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result tdata=%h tuser=%b", $time, td, tu);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (td[2:0] !== e.sector) begin
        $display("%0t: sector expected %0d actual %0d", $time, e.sector, td[2:0]);
        errors++;
      end
      if (td[18:3] !== e.duty_a) begin
        $display("%0t: duty_a expected %0d actual %0d", $time, e.duty_a, td[18:3]);
        errors++;
      end
      if (td[34:19] !== e.duty_b) begin
        $display("%0t: duty_b expected %0d actual %0d", $time, e.duty_b, td[34:19]);
        errors++;
      end
      if (td[50:35] !== e.duty_c) begin
        $display("%0t: duty_c expected %0d actual %0d", $time, e.duty_c, td[50:35]);
        errors++;
      end
      if (td[55:51] !== 5'd0) begin
        $display("%0t: pad expected 0 actual %h", $time, td[55:51]);
        errors++;
      end
      if (tu[0] !== e.fault) begin
        $display("%0t: fault expected %b actual %b", $time, e.fault, tu[0]);
        errors++;
      end
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [IN_W-1:0]                 s_axis_tdata_i = '0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [svd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [svd_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o;

  duty_scoreboard sb = new();
  bit             idle_en = 1'b1;
  int             quiet_cycles = 0;

  svpwm_sector_duty_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_duties(m_axis_tdata_o, m_axis_tuser_o);
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("Simulation FAILED");
        $finish;
      end
      m_axis_tready_i <= idle_en ? ($urandom_range(99) >= 30) : 1'b1;
    end
  end

  task automatic send_vector(logic signed [VW-1:0] a, logic signed [VW-1:0] b,
                             logic [VW-1:0] vbus);
    while (idle_en && $urandom_range(99) < 30) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {vbus, b, a};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_vector({vbus, b, a});
  endtask

  task automatic send_random();
    logic [VW-1:0] a, b, v;
    a = VW'($urandom);
    b = VW'($urandom);
    case ($urandom_range(5))
      0: v = VW'($urandom);
      1: v = VW'($urandom_range(2000));
      2: v = VW'($urandom_range(40000, 20000));
      3: begin
        v = VW'($urandom_range(3));
        a = VW'($urandom_range(50));
        b = VW'($urandom_range(50) - 25);
      end
      4: begin
        v = VW'($urandom);
        if ($urandom_range(1)) b = '0; else a = '0;
      end
      default: v = VW'($urandom_range(65535, 60000));
    endcase
    send_vector(a, b, v);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_vector(0, 0, 100);
    send_vector(0, 0, 0);
    send_vector(1000, 577, 0);
    send_vector(1000, 577, 4000);
    send_vector(0, 1000, 4000);
    send_vector(-1000, 577, 4000);
    send_vector(-1000, -577, 4000);
    send_vector(0, -1000, 4000);
    send_vector(1000, -577, 4000);
    send_vector(30000, 0, 1000);
    send_vector(-30000, 0, 1000);
    send_vector(32767, 32767, 65535);
    send_vector(-32768, -32768, 65535);
    send_vector(-32768, 32767, 1);
    send_vector(32767, -32768, 1);
    send_vector(32767, 0, 65535);
    send_vector(0, 32767, 65535);
    send_vector(0, -32768, 1);
    send_vector(1, 0, 1);
    send_vector(-1, 0, 1);
    send_vector(20000, 11547, 20000);
    send_vector(-20000, -11547, 65535);
    for (int i = 0; i < N_RAND; i++) begin
      idle_en = !(i >= 400 && i < 600);
      if (i == 700) begin
        s_axis_tvalid_i <= 1'b0;
        do @(posedge clk_i); while (sb.pending_q.size() != 0);
      end
      send_random();
    end
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_q.size() != 0);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
src/svd_pkg.sv
src/svd_div.sv
src/svpwm_sector_duty_core.sv
src/svd_checker.sv
bench/svpwm_sector_duty_core_tb.sv
